/* src/ctc_pkg.sv */
// Package for the columnar transposition cipher block.
// Holds the channel payload types, register indexes and cipher constants.
// No dependencies.
package ctc_pkg;

    // Matrix geometry and padding
    localparam int unsigned NUM_COLS     = 8;
    localparam int unsigned COL_W        = 3;
    localparam int unsigned CTC_MAX_ROWS = 8;
    localparam logic [7:0]  PAD_CHAR     = 8'h40;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_KEY  = 1'b1;

    // Mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Identity key: entry i holds i
    localparam logic [CFG_DATA_W-1:0] KEY_RESET = 24'd16434824;

    // Input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // Result transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       overflow;
    } out_item_t;

endpackage

/* src/columnar_transposition_cipher.sv */
// Columnar transposition cipher: message buffer in a synchronous RAM and a
// keyed read-out sequencer over eight columns.
// Depends on ctc_pkg.
//
//  channel   signals                          direction  transfer when
//  -------   -------------------------------  ---------  ----------------------
//  input     start, busy, item                in         start && !busy
//  result    result_valid, result             out        result_valid (1 cycle)
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// Loading takes one byte per cycle while busy is low, each written into the
// message RAM while there is room. A byte with last_byte set starts the
// read-out: busy rises the next cycle and stays high through the last result;
// results follow one per cycle, paced by the single registered RAM read port.
// Reset clears the count and flags and sets encrypt mode and the identity key; the RAM is not cleared.
// The receiver cannot stall; results are strobed for exactly one cycle.
module columnar_transposition_cipher #(
    parameter int unsigned MAX_ROWS = ctc_pkg::CTC_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ctc_pkg::in_item_t                   item,
    output logic                                result_valid,
    output ctc_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ctc_pkg::*;

    localparam int unsigned CAP = MAX_ROWS * NUM_COLS;
    localparam int unsigned AW  = $clog2(CAP);
    localparam int unsigned CW  = $clog2(CAP + 1);
    localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
    localparam int unsigned YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  dropped_reg, dropped_next;
    logic                  mode_reg, mode_next;
    logic [CFG_DATA_W-1:0] key_reg, key_next;
    logic [YW-1:0]         row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  valid_reg, valid_next;
    logic [RW-1:0]         rows_reg, rows_next;

    // Read pipeline payload
    logic [7:0]            rd_data_reg;
    logic                  pad_reg, end_reg, ovf_reg;

    logic [7:0]            message_store [CAP];

    logic                  accept;
    logic                  room;
    logic [CW-1:0]         new_count;
    logic [COL_W-1:0]      inv [NUM_COLS];
    logic                  last_row, last_col, last_issue;
    logic [CW-1:0]         pos;
    logic [COL_W-1:0]      key_col;

    assign accept = start && !busy;
    assign room   = (count_reg < CW'(CAP));
    assign busy   = (state_reg == ST_DRAIN) || valid_reg;

    // Inverse key: lowest column whose entry equals x, else x itself
    always_comb
    begin
        for (int x = 0; x < NUM_COLS; x++)
        begin
            inv[x] = COL_W'(x);
            for (int i = NUM_COLS - 1; i >= 0; i--)
            begin
                if (key_reg[COL_W*i +: COL_W] == COL_W'(x))
                    inv[x] = COL_W'(i);
            end
        end
    end

    // Read address for the current output position
    assign key_col  = key_reg[COL_W*col_reg +: COL_W];
    assign last_row = ((RW'(row_reg) + RW'(1)) == rows_reg);
    assign last_col = (col_reg == COL_W'(NUM_COLS - 1));
    assign last_issue = (state_reg == ST_DRAIN) && last_row && last_col;

    always_comb
    begin
        if (mode_reg == MODE_ENCRYPT)
            pos = CW'({row_reg, inv[col_reg]});
        else
            pos = (CW'(key_col) * CW'(rows_reg)) + CW'(row_reg);
    end

    // Byte count once the current byte is stored
    assign new_count = room ? (count_reg + CW'(1)) : count_reg;

    // Control next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        rows_next    = rows_reg;
        valid_next   = (state_reg == ST_DRAIN);

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CIPHER_MODE: mode_next = cfg_data[0];
                REG_COLUMN_KEY:  key_next  = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = new_count;
                    if (!room)
                        dropped_next = 1'b1;
                    if (item.last_byte)
                    begin
                        state_next = ST_DRAIN;
                        rows_next  = RW'((new_count + CW'(NUM_COLS - 1)) >> COL_W);
                        row_next   = '0;
                        col_next   = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (mode_reg == MODE_ENCRYPT)
                begin
                    // column outer, row inner
                    if (last_row)
                    begin
                        row_next = '0;
                        col_next = col_reg + COL_W'(1);
                    end
                    else
                        row_next = row_reg + YW'(1);
                end
                else
                begin
                    // row outer, column inner
                    col_next = col_reg + COL_W'(1);
                    if (last_col)
                        row_next = row_reg + YW'(1);
                end
                if (last_issue)
                begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                    row_next     = '0;
                    col_next     = '0;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            mode_reg    <= MODE_ENCRYPT;
            key_reg     <= KEY_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            valid_reg   <= 1'b0;
            rows_reg    <= RW'(1);
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            mode_reg    <= mode_next;
            key_reg     <= key_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            valid_reg   <= valid_next;
            rows_reg    <= rows_next;
        end
    end

    // Message RAM: one write port for loading, one registered read port.
    // Every write of a run lands before the first read of that run, so no bypass.
    always_ff @(posedge clk)
    begin
        if (accept && room)
            message_store[count_reg[AW-1:0]] <= item.data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DRAIN)
            rd_data_reg <= message_store[pos[AW-1:0]];
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DRAIN)
        begin
            pad_reg <= (pos >= count_reg);
            end_reg <= last_row && last_col;
            ovf_reg <= dropped_reg;
        end
    end

    assign result_valid        = valid_reg;
    assign result.out_byte     = pad_reg ? PAD_CHAR : rd_data_reg;
    assign result.end_of_run   = end_reg;
    assign result.overflow     = ovf_reg;

    // Checks
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (pos < CW'(CAP)))
        else $error("read address beyond buffer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("stored count beyond capacity");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.end_of_run) |=> !result_valid)
        else $error("result after end of run");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_byte) |=> (state_reg == ST_DRAIN && busy))
        else $error("last byte did not start read-out");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        last_issue |=> (count_reg == '0 && !dropped_reg && result_valid))
        else $error("state not cleared after run");

endmodule
